FILE: src/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared action codes, widths and the result record passed between modules.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int TPP_W = 10;
    localparam int ACTION_W = 3;
    localparam int BYTE_W = 8;
    localparam int BIT_CNT_W = 4;

    localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

    localparam logic [TPP_W-1:0] TPP_RESET = 10'd2;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic              scl_high;
        logic              sda_drive_low;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_missing;
    } result_t;

endpackage

FILE: src/i2cmbe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit sequencer
// Holds the bus sequencing state and advances it by one tick per transfer;
// produces that tick's result combinationally.
// ----------------------------------------------------------------------------
module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [ACTION_W-1:0] action,
    input  logic [BYTE_W-1:0]   tx_byte,
    input  logic                send_nack,
    input  logic                sda_in,
    input  logic [TPP_W-1:0]    ticks_per_phase,
    output result_t             result
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_START_REL, ST_START_LOW, ST_STOP_LOW, ST_STOP_HIGH,
        ST_WR_LO, ST_WR_HI, ST_WACK_LO, ST_WACK_HI,
        ST_RD_LO, ST_RD_HI, ST_RACK_LO, ST_RACK_HI
    } state_t;

    state_t               state_reg, state_next;
    logic [TPP_W-1:0]     phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [BYTE_W-1:0]    rx_reg, rx_next;
    logic                 nack_reg, nack_next;
    logic                 ack_reg, ack_next;
    logic                 scl_reg, scl_next;
    logic                 sda_low_reg, sda_low_next;

    logic [TPP_W-1:0]     tpp;
    logic                 last;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic [BYTE_W-1:0]    rd_shift;
    logic                 o_scl, o_sda, busy, done;

    assign tpp = (ticks_per_phase == '0) ? TPP_W'(1) : ticks_per_phase;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        rx_next      = rx_reg;
        nack_next    = nack_reg;
        ack_next     = ack_reg;
        scl_next     = scl_reg;
        sda_low_next = sda_low_reg;
        o_scl        = scl_reg;
        o_sda        = sda_low_reg;
        busy         = 1'b0;
        done         = 1'b0;

        // A command is only taken while the engine is idle.
        if (state_reg == ST_IDLE) begin
            case (action)
                ACT_START: begin
                    state_next = ST_START_REL;
                end
                ACT_STOP: begin
                    state_next = ST_STOP_LOW;
                end
                ACT_WRITE: begin
                    state_next = ST_WR_LO;
                    shift_next = tx_byte;
                end
                ACT_READ: begin
                    state_next = ST_RD_LO;
                    shift_next = '0;
                    nack_next  = send_nack;
                end
                default: begin
                end
            endcase
            if (state_next != ST_IDLE) begin
                phase_next   = '0;
                bit_idx_next = '0;
            end
        end

        last     = ({1'b0, phase_next} + 11'd1) >= {1'b0, tpp};
        bit_inc  = bit_idx_next + BIT_CNT_W'(1);
        rd_shift = {shift_next[BYTE_W-2:0], sda_in};

        if (state_next != ST_IDLE) begin
            busy = 1'b1;
            case (state_next)
                ST_START_REL: begin o_scl = 1'b1; o_sda = 1'b0; end
                ST_START_LOW: begin o_scl = 1'b1; o_sda = 1'b1; end
                ST_STOP_LOW:  begin o_scl = 1'b0; o_sda = 1'b1; end
                ST_STOP_HIGH: begin o_scl = 1'b1; o_sda = 1'b1; end
                ST_WR_LO:     begin o_scl = 1'b0; o_sda = ~shift_next[BYTE_W-1]; end
                ST_WR_HI:     begin o_scl = 1'b1; o_sda = ~shift_next[BYTE_W-1]; end
                ST_WACK_LO:   begin o_scl = 1'b0; o_sda = 1'b0; end
                ST_WACK_HI:   begin o_scl = 1'b1; o_sda = 1'b0; end
                ST_RD_LO:     begin o_scl = 1'b0; o_sda = 1'b0; end
                ST_RD_HI:     begin o_scl = 1'b1; o_sda = 1'b0; end
                ST_RACK_LO:   begin o_scl = 1'b0; o_sda = ~nack_next; end
                default:      begin o_scl = 1'b1; o_sda = ~nack_next; end
            endcase

            if (!last) begin
                phase_next = phase_next + TPP_W'(1);
            end else begin
                phase_next = '0;
                case (state_next)
                    ST_START_REL: state_next = ST_START_LOW;
                    ST_START_LOW: begin
                        state_next = ST_IDLE; scl_next = 1'b0; sda_low_next = 1'b1;
                        done = 1'b1;
                    end
                    ST_STOP_LOW: state_next = ST_STOP_HIGH;
                    ST_STOP_HIGH: begin
                        state_next = ST_IDLE; scl_next = 1'b1; sda_low_next = 1'b0;
                        done = 1'b1;
                    end
                    ST_WR_LO: state_next = ST_WR_HI;
                    ST_WR_HI: begin
                        shift_next   = {shift_next[BYTE_W-2:0], 1'b0};
                        bit_idx_next = bit_inc;
                        state_next   = (bit_inc >= BITS_PER_BYTE) ? ST_WACK_LO : ST_WR_LO;
                    end
                    ST_WACK_LO: state_next = ST_WACK_HI;
                    ST_WACK_HI: begin
                        ack_next   = sda_in;
                        state_next = ST_IDLE; scl_next = 1'b0; sda_low_next = 1'b0;
                        done = 1'b1;
                    end
                    ST_RD_LO: state_next = ST_RD_HI;
                    ST_RD_HI: begin
                        shift_next   = rd_shift;
                        bit_idx_next = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            rx_next    = rd_shift;
                            state_next = ST_RACK_LO;
                        end else begin
                            state_next = ST_RD_LO;
                        end
                    end
                    ST_RACK_LO: state_next = ST_RACK_HI;
                    default: begin
                        state_next = ST_IDLE; scl_next = 1'b0; sda_low_next = 1'b0;
                        done = 1'b1;
                    end
                endcase
            end
        end

        result.scl_high      = o_scl;
        result.sda_drive_low = o_sda;
        result.busy          = busy;
        result.done          = done;
        result.rx_byte       = rx_next;
        result.ack_missing   = ack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            rx_reg      <= '0;
            nack_reg    <= 1'b0;
            ack_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_low_reg <= 1'b0;
        end else if (step) begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            rx_reg      <= rx_next;
            nack_reg    <= nack_next;
            ack_reg     <= ack_next;
            scl_reg     <= scl_next;
            sda_low_reg <= sda_low_next;
        end
    end

endmodule

FILE: src/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Each input transfer is one bus tick carrying the sampled SDA level and,
// while idle, a command: start, stop, write byte or read byte. Each tick
// produces exactly one result transfer with the SCL/SDA drive levels,
// busy/done flags, the last received byte and the last acknowledge status.
// The s_ channel is valid/ready; the m_ channel is valid/ready; cfg_we writes
// ticks_per_phase (reset 2, zero acts as 1) and is meant to be used only
// while no transfer is in flight and the engine is idle.
// A tick taken at a clock edge has its result registered on m_ at that same
// edge. Throughput is one tick per cycle while the receiver keeps up, set by
// the single-pass sequencer update feeding the result register.
// If the receiver stalls, the result register holds and s_ready drops until
// the result is taken; a new tick is taken in the same cycle a result leaves.
// Reset (aresetn low, synchronous) returns to idle with SCL released high,
// SDA released, and empties the result register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [TPP_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [BYTE_W-1:0]   s_tx_byte,
    input  logic                s_send_nack,
    input  logic                s_sda_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_scl_high,
    output logic                m_sda_drive_low,
    output logic                m_busy_res,
    output logic                m_done_res,
    output logic [BYTE_W-1:0]   m_rx_byte,
    output logic                m_ack_missing
);

    logic [TPP_W-1:0] tpp_reg;
    logic             accept;
    result_t          result;
    result_t          out_reg;
    logic             out_valid_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpp_reg <= TPP_RESET;
        end else if (cfg_we) begin
            tpp_reg <= cfg_wdata;
        end
    end

    i2cmbe_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (accept),
        .action          (s_action),
        .tx_byte         (s_tx_byte),
        .send_nack       (s_send_nack),
        .sda_in          (s_sda_in),
        .ticks_per_phase (tpp_reg),
        .result          (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_scl_high      = out_reg.scl_high;
    assign m_sda_drive_low = out_reg.sda_drive_low;
    assign m_busy_res      = out_reg.busy;
    assign m_done_res      = out_reg.done;
    assign m_rx_byte       = out_reg.rx_byte;
    assign m_ack_missing   = out_reg.ack_missing;

    // A completed command is always flagged busy on its last tick.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done result without busy");

    // Input only stalls when a result is waiting and not being taken.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    // Every accepted tick yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted tick produced no result");

    // A done pulse leaves the engine idle, so the following tick is not busy
    // unless it carries a new command.
    a_done_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result.done ##1 accept && s_action == ACT_NONE |-> !result.busy)
        else $error("engine still busy after done");

endmodule
